### rtl/ims_pkg.sv
// Shared types and codes of the Ising Metropolis spin-flip block.
// No dependencies.
package ims_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FOUR  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_EIGHT = 1'b1;

	localparam logic OP_ATTEMPT = 1'b0;
	localparam logic OP_SET     = 1'b1;

	localparam int DE_W   = 5;
	localparam int ENG_W  = 13;
	localparam int MAG_W  = 12;
	localparam int CNT_W  = 32;
	localparam int DRAW_W = 32;
	localparam int COORD_IN_W = 5;

	typedef struct packed {
		logic                   flip;
		logic                   spin_new;
		logic                   accepted;
		logic signed [DE_W-1:0] delta;
	} eval_t;

endpackage

### rtl/ims_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/ims_eval.sv
// Neighbor sum, energy change and flip decision (Metropolis attempt or forced set) for one site.
// Depends on ims_pkg.
module ims_eval #(
	parameter int SIDE = 32
) (
	input  logic [SIDE-1:0]           row_up,
	input  logic [SIDE-1:0]           row_mid,
	input  logic [SIDE-1:0]           row_dn,
	input  logic [$clog2(SIDE)-1:0]   col,
	input  logic                      op,
	input  logic [ims_pkg::DRAW_W-1:0] draw,
	input  logic                      want,
	input  logic [ims_pkg::DRAW_W-1:0] weight_four,
	input  logic [ims_pkg::DRAW_W-1:0] weight_eight,
	output ims_pkg::eval_t            res
);
	import ims_pkg::*;

	localparam int CW = $clog2(SIDE);

	logic [CW-1:0] col_left;
	logic [CW-1:0] col_right;
	logic          s;
	logic [2:0]    n_up;
	logic [2:0]    k;
	logic          flip;

	always_comb begin
		col_left  = (col == '0) ? CW'(SIDE - 1) : col - CW'(1);
		col_right = (col == CW'(SIDE - 1)) ? '0 : col + CW'(1);
		s = row_mid[col];
		n_up = 3'(row_up[col]) + 3'(row_dn[col]) + 3'(row_mid[col_left])
		     + 3'(row_mid[col_right]);
		// aligned neighbors counted from the site's own point of view
		k = s ? n_up : 3'd4 - n_up;
		res.delta = $signed(DE_W'({k, 2'b00}) - DE_W'(8));
		if (op == OP_SET) begin
			flip = (s != want);
		end else begin
			flip = (k <= 3'd2) || ((k == 3'd3) && (draw <= weight_four))
			    || ((k == 3'd4) && (draw <= weight_eight));
		end
		res.flip     = flip;
		res.spin_new = flip ? ~s : s;
		res.accepted = flip && (op == OP_ATTEMPT);
	end

endmodule

### rtl/ising_metropolis_spin_flip.sv
// Metropolis spin-flip unit for a periodic SIDE x SIDE Ising lattice. Each request
// is accepted in the idle step and then reads the rows above, at and below the site
// through the single read port of the row-wide lattice RAM; the row is written back
// in the last step. Requests are taken one at a time; the
// result sits in an output register and the next request may be accepted while it
// waits, but the unit holds in its last step until the previous result is taken.
// Spins reset to up through per-row valid flags, so no clearing pass follows reset.
// Depends on ims_pkg, ims_ram and ims_eval.
module ising_metropolis_spin_flip #(
	parameter int SIDE = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ims_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ims_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [ims_pkg::COORD_IN_W-1:0]      column,
	input  logic [ims_pkg::COORD_IN_W-1:0]      row,
	input  logic [ims_pkg::DRAW_W-1:0]          draw,
	input  logic                                set_spin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                flipped,
	output logic                                spin_now,
	output logic signed [ims_pkg::DE_W-1:0]     delta_energy,
	output logic signed [ims_pkg::ENG_W-1:0]    energy,
	output logic signed [ims_pkg::MAG_W-1:0]    magnetization,
	output logic [ims_pkg::CNT_W-1:0]           accept_count
);
	import ims_pkg::*;

	localparam int CW    = $clog2(SIDE);
	localparam int SITES = SIDE * SIDE;
	localparam int EW    = ($clog2(SITES) + 3 > ENG_W) ? $clog2(SITES) + 3 : ENG_W;
	localparam int MW    = ($clog2(SITES) + 2 > MAG_W) ? $clog2(SITES) + 2 : MAG_W;
	localparam int TAB_N = 2 ** COORD_IN_W;

	typedef logic [CW-1:0] coord_tab_t [TAB_N];

	function automatic coord_tab_t build_tab();
		coord_tab_t tab;
		int v;
		for (int i = 0; i < TAB_N; i++) begin
			v = i;
			for (int j = 0; j < TAB_N; j++) begin
				if (v >= SIDE) begin
					v = v - SIDE;
				end
			end
			tab[i] = CW'(v);
		end
		return tab;
	endfunction

	localparam coord_tab_t COORD_TAB = build_tab();

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MID  = 4'b0010,
		ST_DN   = 4'b0100,
		ST_EVAL = 4'b1000
	} state_t;

	state_t               state_q;
	logic [DRAW_W-1:0]    weight_four_q;
	logic [DRAW_W-1:0]    weight_eight_q;
	logic                 op_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        row_q;
	logic [DRAW_W-1:0]    draw_q;
	logic                 want_q;
	logic [SIDE-1:0]      row_up_q;
	logic [SIDE-1:0]      row_mid_q;
	logic [SIDE-1:0]      row_valid_q;
	logic                 rd_valid_q;
	logic signed [EW-1:0] energy_q;
	logic signed [MW-1:0] magnet_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic                 flipped_q;
	logic                 spin_q;
	logic [DE_W-1:0]      de_q;

	logic [CW-1:0]        in_row;
	logic [CW-1:0]        in_row_up;
	logic [CW-1:0]        row_dn;
	logic [CW-1:0]        raddr;
	logic [SIDE-1:0]      ram_rdata;
	logic [SIDE-1:0]      row_eff;
	logic [SIDE-1:0]      wdata;
	logic                 out_free;
	logic                 do_eval;
	eval_t                res;

	assign in_row    = COORD_TAB[row];
	assign in_row_up = (in_row == '0) ? CW'(SIDE - 1) : in_row - CW'(1);
	assign row_dn    = (row_q == CW'(SIDE - 1)) ? '0 : row_q + CW'(1);
	assign row_eff   = rd_valid_q ? ram_rdata : '1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign do_eval   = (state_q == ST_EVAL) && out_free;

	always_comb begin
		unique case (state_q)
			ST_IDLE: raddr = in_row_up;
			ST_MID:  raddr = row_q;
			ST_DN:   raddr = row_dn;
			ST_EVAL: raddr = row_dn;
			default: raddr = row_q;
		endcase
	end

	always_comb begin
		wdata = row_mid_q;
		wdata[col_q] = res.spin_new;
	end

	ims_ram #(
		.WIDTH(SIDE),
		.DEPTH(SIDE)
	) u_lattice (
		.clk  (clk),
		.we   (do_eval),
		.waddr(row_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	ims_eval #(
		.SIDE(SIDE)
	) u_eval (
		.row_up      (row_up_q),
		.row_mid     (row_mid_q),
		.row_dn      (row_eff),
		.col         (col_q),
		.op          (op_q),
		.draw        (draw_q),
		.want        (want_q),
		.weight_four (weight_four_q),
		.weight_eight(weight_eight_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_four_q  <= '0;
			weight_eight_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WEIGHT_FOUR:  weight_four_q  <= cfg_data;
				REG_WEIGHT_EIGHT: weight_eight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			energy_q    <= EW'(-2 * SITES);
			magnet_q    <= MW'(SITES);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= row_valid_q[raddr];
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MID;
				ST_MID:  state_q <= ST_DN;
				ST_DN:   state_q <= ST_EVAL;
				ST_EVAL: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (do_eval) begin
				row_valid_q[row_q] <= 1'b1;
				out_valid_q <= 1'b1;
				if (res.flip) begin
					energy_q <= energy_q + EW'(res.delta);
					magnet_q <= res.spin_new ? magnet_q + MW'(2) : magnet_q - MW'(2);
				end
				if (res.accepted && (count_q != '1)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			col_q  <= COORD_TAB[column];
			row_q  <= in_row;
			draw_q <= draw;
			want_q <= set_spin;
		end
		if (state_q == ST_MID) begin
			row_up_q <= row_eff;
		end
		if (state_q == ST_DN) begin
			row_mid_q <= row_eff;
		end
		if (do_eval) begin
			flipped_q <= res.flip;
			spin_q    <= res.spin_new;
			de_q      <= res.delta;
		end
	end

	assign out_valid     = out_valid_q;
	assign flipped       = flipped_q;
	assign spin_now      = spin_q;
	assign delta_energy  = $signed(de_q);
	assign energy        = energy_q[ENG_W-1:0];
	assign magnetization = magnet_q[MAG_W-1:0];
	assign accept_count  = count_q;

endmodule

### test/spin_flip_checker.sv
`timescale 1ns / 1ps
// Checker for the Ising Metropolis spin-flip unit: mirrors the weights, lattice and totals,
// predicts one result per accepted request and compares each result as it is taken.
// Depends on ims_pkg.
module spin_flip_checker #(
	parameter int SIDE = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ims_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ims_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                opcode,
	input  logic [ims_pkg::COORD_IN_W-1:0]      column,
	input  logic [ims_pkg::COORD_IN_W-1:0]      row,
	input  logic [ims_pkg::DRAW_W-1:0]          draw,
	input  logic                                set_spin,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                flipped,
	input  logic                                spin_now,
	input  logic signed [ims_pkg::DE_W-1:0]     delta_energy,
	input  logic signed [ims_pkg::ENG_W-1:0]    energy,
	input  logic signed [ims_pkg::MAG_W-1:0]    magnetization,
	input  logic [ims_pkg::CNT_W-1:0]           accept_count,
	output int                                  mismatches,
	output int                                  outstanding
);
	import ims_pkg::*;

	typedef struct packed {
		logic                    flip;
		logic                    spin;
		logic signed [DE_W-1:0]  de;
		logic signed [ENG_W-1:0] eng;
		logic signed [MAG_W-1:0] mag;
		logic [CNT_W-1:0]        count;
	} spin_result_t;

	logic                  spins [SIDE*SIDE];
	int                    energy_sum;
	int                    magnet_sum;
	logic [CNT_W-1:0]      accepted;
	logic [CFG_DATA_W-1:0] weight_four;
	logic [CFG_DATA_W-1:0] weight_eight;
	spin_result_t          results_due [$];
	int                    fail_total;

	function automatic int spin_sign(input int r, input int c);
		return spins[r * SIDE + c] ? 1 : -1;
	endfunction

	function automatic spin_result_t metropolis_step(input logic op,
			input logic [COORD_IN_W-1:0] x, input logic [COORD_IN_W-1:0] y,
			input logic [DRAW_W-1:0] u, input logic want);
		int c, r, at, nsum, de;
		logic take;
		spin_result_t res;
		c = int'(x) % SIDE;
		r = int'(y) % SIDE;
		at = r * SIDE + c;
		nsum = spin_sign(r, (c + SIDE - 1) % SIDE) + spin_sign((r + SIDE - 1) % SIDE, c)
			+ spin_sign(r, (c + 1) % SIDE) + spin_sign((r + 1) % SIDE, c);
		de = 2 * (spins[at] ? 1 : -1) * nsum;
		if (op == OP_ATTEMPT) begin
			if (de <= 0)
				take = 1'b1;
			else if (de == 4)
				take = (u <= weight_four);
			else
				take = (u <= weight_eight);
			if (take && accepted != '1)
				accepted = accepted + 1'b1;
		end else begin
			take = (spins[at] != want);
		end
		if (take) begin
			spins[at] = ~spins[at];
			energy_sum = energy_sum + de;
			magnet_sum = magnet_sum + (spins[at] ? 2 : -2);
		end
		res.flip  = take;
		res.spin  = spins[at];
		res.de    = de[DE_W-1:0];
		res.eng   = energy_sum[ENG_W-1:0];
		res.mag   = magnet_sum[MAG_W-1:0];
		res.count = accepted;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		spin_result_t due, seen;
		if (!arst_n) begin
			foreach (spins[i])
				spins[i] = 1'b1;
			energy_sum = -2 * SIDE * SIDE;
			magnet_sum = SIDE * SIDE;
			accepted = '0;
			weight_four = '0;
			weight_eight = '0;
			results_due.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_WEIGHT_FOUR)
					weight_four = cfg_data;
				else if (cfg_index == REG_WEIGHT_EIGHT)
					weight_eight = cfg_data;
			end
			if (out_valid && out_ready) begin
				seen = {flipped, spin_now, delta_energy, energy, magnetization, accept_count};
				if (results_due.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: result with no request pending: flip=%0b spin=%0b",
							$realtime, seen.flip, seen.spin);
					fail_total++;
				end else begin
					due = results_due.pop_front();
					if (due.flip !== seen.flip || due.spin !== seen.spin
							|| due.de !== seen.de || due.eng !== seen.eng
							|| due.mag !== seen.mag || due.count !== seen.count) begin
						if (fail_total < 10) begin
							$display("%0t: expected flip=%0b spin=%0b dE=%0d E=%0d M=%0d acc=%0d",
								$realtime, due.flip, due.spin, due.de, due.eng, due.mag,
								due.count);
							$display("%0t: actual   flip=%0b spin=%0b dE=%0d E=%0d M=%0d acc=%0d",
								$realtime, seen.flip, seen.spin, seen.de, seen.eng, seen.mag,
								seen.count);
						end
						fail_total++;
					end
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(metropolis_step(opcode, column, row, draw, set_spin));
			mismatches <= fail_total;
			outstanding <= results_due.size();
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Top of the spin-flip testbench: clock, reset, request stimulus, bursty sender and
// stalling receiver, watchdog and verdict. Depends on ims_pkg, the block and spin_flip_checker.
module testbench;
	import ims_pkg::*;

	localparam int SIDE = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 310;
	localparam logic [DRAW_W-1:0] FRACTION_MAX = '1;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   opcode;
	logic [COORD_IN_W-1:0]  column;
	logic [COORD_IN_W-1:0]  row;
	logic [DRAW_W-1:0]      draw;
	logic                   set_spin;
	logic                   out_valid;
	logic                   out_ready;
	logic                   flipped;
	logic                   spin_now;
	logic signed [DE_W-1:0] delta_energy;
	logic signed [ENG_W-1:0] energy;
	logic signed [MAG_W-1:0] magnetization;
	logic [CNT_W-1:0]       accept_count;
	int                     mismatches;
	int                     outstanding;

	logic [CFG_DATA_W-1:0]  w_four;
	logic [CFG_DATA_W-1:0]  w_eight;
	logic [COORD_IN_W-1:0]  hot_x;
	logic [COORD_IN_W-1:0]  hot_y;
	ready_mode_t            ready_mode;
	int                     ready_span;

	ising_metropolis_spin_flip #(.SIDE(SIDE)) uut (.*);

	spin_flip_checker #(.SIDE(SIDE)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_mode <= RDY_ALWAYS;
			ready_span <= 0;
		end else begin
			if (ready_span == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				ready_span <= $urandom_range(20, 120);
			end else begin
				ready_span <= ready_span - 1;
			end
			case (ready_mode)
				RDY_ALWAYS: begin
					out_ready <= 1'b1;
				end
				RDY_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				RDY_SPARSE: begin
					out_ready <= ($urandom_range(0, 5) == 0);
				end
				default: begin
					out_ready <= (ready_span % 8) < 3;
				end
			endcase
		end
	end

	task automatic send_req(input logic op, input logic [COORD_IN_W-1:0] x,
			input logic [COORD_IN_W-1:0] y, input logic [DRAW_W-1:0] u, input logic s);
		in_valid <= 1'b1;
		opcode <= op;
		column <= x;
		row <= y;
		draw <= u;
		set_spin <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_weights(input logic [CFG_DATA_W-1:0] four,
			input logic [CFG_DATA_W-1:0] eight);
		w_four = four;
		w_eight = eight;
		cfg_write <= 1'b1;
		cfg_index <= REG_WEIGHT_FOUR;
		cfg_data <= four;
		@(posedge clk);
		cfg_index <= REG_WEIGHT_EIGHT;
		cfg_data <= eight;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int burst;
		logic op, s;
		logic [COORD_IN_W-1:0] x, y;
		logic [DRAW_W-1:0] u;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
			burst--;
			if ($urandom_range(0, 31) == 0) begin
				hot_x = COORD_IN_W'($urandom_range(0, 31));
				hot_y = COORD_IN_W'($urandom_range(0, 31));
			end
			op = ($urandom_range(0, 3) == 0) ? OP_SET : OP_ATTEMPT;
			s = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				x = hot_x + COORD_IN_W'($urandom_range(0, 3));
				y = hot_y + COORD_IN_W'($urandom_range(0, 3));
			end else begin
				x = COORD_IN_W'($urandom_range(0, 31));
				y = COORD_IN_W'($urandom_range(0, 31));
			end
			case ($urandom_range(0, 9))
				0: u = '0;
				1: u = FRACTION_MAX;
				2, 3: u = w_four + $urandom_range(0, 4) - 2;
				4, 5: u = w_eight + $urandom_range(0, 4) - 2;
				default: u = $urandom();
			endcase
			send_req(op, x, y, u, s);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_WEIGHT_FOUR;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_ATTEMPT;
		column <= '0;
		row <= '0;
		draw <= '0;
		set_spin <= 1'b0;
		hot_x = '0;
		hot_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero weights: only downhill or level moves, except a zero draw
		set_weights('0, '0);
		send_req(OP_ATTEMPT, 0, 0, '0, 1'b0);
		send_req(OP_ATTEMPT, 0, 0, FRACTION_MAX, 1'b1);
		send_req(OP_ATTEMPT, 31, 31, 1, 1'b0);
		send_req(OP_SET, 31, 31, FRACTION_MAX, 1'b1);
		send_req(OP_SET, 0, 31, 0, 1'b0);
		send_req(OP_ATTEMPT, 0, 0, '0, 1'b1);
		send_req(OP_ATTEMPT, 0, 0, FRACTION_MAX, 1'b0);
		send_req(OP_SET, 31, 0, 0, 1'b0);
		send_req(OP_ATTEMPT, 0, 0, FRACTION_MAX, 1'b0);
		send_req(OP_SET, 0, 0, 0, 1'b1);
		send_req(OP_SET, 5, 7, 0, 1'b0);
		send_req(OP_SET, 5, 7, FRACTION_MAX, 1'b0);
		send_req(OP_SET, 5, 7, 0, 1'b1);
		send_req(OP_ATTEMPT, 31, 0, FRACTION_MAX, 1'b0);
		send_req(OP_ATTEMPT, 0, 31, FRACTION_MAX, 1'b0);
		drain_results();

		set_weights(FRACTION_MAX, FRACTION_MAX);
		send_req(OP_ATTEMPT, 31, 0, FRACTION_MAX, 1'b0);
		send_req(OP_ATTEMPT, 30, 0, FRACTION_MAX, 1'b1);
		send_req(OP_ATTEMPT, 17, 31, 32'h8000_0000, 1'b0);
		drain_results();

		// boundary of the draw compare, one step either side
		set_weights(32'h8000_0000, 32'h7FFF_FFFF);
		send_req(OP_ATTEMPT, 29, 0, 32'h8000_0001, 1'b0);
		send_req(OP_ATTEMPT, 29, 0, 32'h8000_0000, 1'b0);
		send_req(OP_ATTEMPT, 10, 10, 32'h8000_0000, 1'b1);
		send_req(OP_ATTEMPT, 10, 10, 32'h7FFF_FFFF, 1'b1);
		drain_results();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_weights(FRACTION_MAX, FRACTION_MAX);
				1: set_weights('0, '0);
				2: set_weights(32'h2BEE_0000, 32'h0787_0000);
				3: set_weights($urandom(), $urandom());
				4: set_weights(32'hC000_0000, 32'h9000_0000);
				default: set_weights('0, FRACTION_MAX);
			endcase
			run_random(PHASE_ITEMS);
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

endmodule
